FILE: src/einm_pkg.sv
package einm_pkg;

   // accumulator holds an exact sum of two 64-bit products
   localparam int ACC_W = 66;
   localparam int PC_W = 5;
   localparam int VERTEX_COUNT = 8;
   localparam int CSR_IDX_W = 4;

   localparam logic [1:0] MODE_LINE = 2'd0;
   localparam logic [1:0] MODE_TRI = 2'd1;
   localparam logic [1:0] MODE_QUAD = 2'd2;

   localparam logic signed [31:0] Q_ONE = 32'sd65536;
   localparam logic signed [31:0] Q_HALF = 32'sd32768;
   localparam logic signed [31:0] Q_THIRD = 32'sd21845;

   // first entry of the jacobian program shared by triangle and quad
   localparam logic [PC_W-1:0] JAC_COMMON_PC = 5'd16;

   typedef struct packed {
      logic [1:0]         mode;
      logic signed [31:0] point_x;
      logic signed [31:0] point_y;
   } req_type;

   typedef struct packed {
      logic signed [31:0] coord_r;
      logic signed [31:0] coord_s;
      logic [3:0]         steps_taken;
      logic               converged;
      logic               singular;
   } rsp_type;

   typedef enum logic [4:0] {
      OPND_V0, OPND_V1, OPND_V2, OPND_V3, OPND_V4, OPND_V5, OPND_V6, OPND_V7,
      OPND_R, OPND_S, OPND_OMR, OPND_OMS, OPND_OTRI,
      OPND_W0, OPND_W1, OPND_W2, OPND_W3,
      OPND_J0, OPND_J1, OPND_J2, OPND_J3,
      OPND_RES0, OPND_RES1
   } opnd_type;

   typedef enum logic [3:0] {
      DST_NONE, DST_W0, DST_W1, DST_W2, DST_W3, DST_RES0, DST_RES1,
      DST_J0, DST_J1, DST_J2, DST_J3, DST_DET, DST_NR, DST_NS
   } dst_type;

   // one multiply-accumulate micro-op
   typedef struct packed {
      opnd_type a;
      opnd_type b;
      logic     clr;
      logic     neg;
      logic     full;
      dst_type  dst;
      logic     last;
   } uop_type;

   function automatic logic signed [ACC_W-1:0] sext32(input logic signed [31:0] x);
      return {{(ACC_W-32){x[31]}}, x};
   endfunction

   function automatic logic signed [31:0] sat32(input logic signed [ACC_W-1:0] x);
      logic signed [ACC_W-1:0] hi;
      logic signed [ACC_W-1:0] lo;
      hi = sext32(32'sh7fffffff);
      lo = sext32(32'sh80000000);
      if (x > hi) begin
         return 32'sh7fffffff;
      end else if (x < lo) begin
         return 32'sh80000000;
      end
      return x[31:0];
   endfunction

   function automatic uop_type mk(input opnd_type a, input opnd_type b, input logic clr,
                                  input logic neg, input logic full, input dst_type dst,
                                  input logic last);
      uop_type u;
      u.a = a;
      u.b = b;
      u.clr = clr;
      u.neg = neg;
      u.full = full;
      u.dst = dst;
      u.last = last;
      return u;
   endfunction

   // residual program: weights (quad) then map sums
   function automatic uop_type uop_res(input logic [1:0] mode, input logic [PC_W-1:0] pc);
      uop_type u;
      u = mk(OPND_V0, OPND_V0, 1'b1, 1'b0, 1'b0, DST_NONE, 1'b1);
      if (mode == MODE_LINE) begin
         case (pc)
            5'd0: u = mk(OPND_V0, OPND_OMR, 1'b1, 1'b0, 1'b0, DST_NONE, 1'b0);
            5'd1: u = mk(OPND_V2, OPND_R, 1'b0, 1'b0, 1'b0, DST_RES0, 1'b1);
            default: ;
         endcase
      end else if (mode == MODE_TRI) begin
         case (pc)
            5'd0: u = mk(OPND_V0, OPND_OTRI, 1'b1, 1'b0, 1'b0, DST_NONE, 1'b0);
            5'd1: u = mk(OPND_V2, OPND_R, 1'b0, 1'b0, 1'b0, DST_NONE, 1'b0);
            5'd2: u = mk(OPND_V4, OPND_S, 1'b0, 1'b0, 1'b0, DST_RES0, 1'b0);
            5'd3: u = mk(OPND_V1, OPND_OTRI, 1'b1, 1'b0, 1'b0, DST_NONE, 1'b0);
            5'd4: u = mk(OPND_V3, OPND_R, 1'b0, 1'b0, 1'b0, DST_NONE, 1'b0);
            5'd5: u = mk(OPND_V5, OPND_S, 1'b0, 1'b0, 1'b0, DST_RES1, 1'b1);
            default: ;
         endcase
      end else begin
         case (pc)
            5'd0:  u = mk(OPND_OMR, OPND_OMS, 1'b1, 1'b0, 1'b0, DST_W0, 1'b0);
            5'd1:  u = mk(OPND_R, OPND_OMS, 1'b1, 1'b0, 1'b0, DST_W1, 1'b0);
            5'd2:  u = mk(OPND_OMR, OPND_S, 1'b1, 1'b0, 1'b0, DST_W2, 1'b0);
            5'd3:  u = mk(OPND_R, OPND_S, 1'b1, 1'b0, 1'b0, DST_W3, 1'b0);
            5'd4:  u = mk(OPND_V0, OPND_W0, 1'b1, 1'b0, 1'b0, DST_NONE, 1'b0);
            5'd5:  u = mk(OPND_V2, OPND_W1, 1'b0, 1'b0, 1'b0, DST_NONE, 1'b0);
            5'd6:  u = mk(OPND_V4, OPND_W2, 1'b0, 1'b0, 1'b0, DST_NONE, 1'b0);
            5'd7:  u = mk(OPND_V6, OPND_W3, 1'b0, 1'b0, 1'b0, DST_RES0, 1'b0);
            5'd8:  u = mk(OPND_V1, OPND_W0, 1'b1, 1'b0, 1'b0, DST_NONE, 1'b0);
            5'd9:  u = mk(OPND_V3, OPND_W1, 1'b0, 1'b0, 1'b0, DST_NONE, 1'b0);
            5'd10: u = mk(OPND_V5, OPND_W2, 1'b0, 1'b0, 1'b0, DST_NONE, 1'b0);
            5'd11: u = mk(OPND_V7, OPND_W3, 1'b0, 1'b0, 1'b0, DST_RES1, 1'b1);
            default: ;
         endcase
      end
      return u;
   endfunction

   // jacobian (quad only), determinant and update numerators
   function automatic uop_type uop_jac(input logic [PC_W-1:0] pc);
      uop_type u;
      u = mk(OPND_V0, OPND_V0, 1'b1, 1'b0, 1'b0, DST_NONE, 1'b1);
      case (pc)
         5'd0:  u = mk(OPND_V0, OPND_OMS, 1'b1, 1'b0, 1'b0, DST_NONE, 1'b0);
         5'd1:  u = mk(OPND_V2, OPND_OMS, 1'b0, 1'b1, 1'b0, DST_NONE, 1'b0);
         5'd2:  u = mk(OPND_V4, OPND_S, 1'b0, 1'b0, 1'b0, DST_NONE, 1'b0);
         5'd3:  u = mk(OPND_V6, OPND_S, 1'b0, 1'b1, 1'b0, DST_J0, 1'b0);
         5'd4:  u = mk(OPND_V0, OPND_OMR, 1'b1, 1'b0, 1'b0, DST_NONE, 1'b0);
         5'd5:  u = mk(OPND_V2, OPND_R, 1'b0, 1'b0, 1'b0, DST_NONE, 1'b0);
         5'd6:  u = mk(OPND_V4, OPND_OMR, 1'b0, 1'b1, 1'b0, DST_NONE, 1'b0);
         5'd7:  u = mk(OPND_V6, OPND_R, 1'b0, 1'b1, 1'b0, DST_J1, 1'b0);
         5'd8:  u = mk(OPND_V1, OPND_OMS, 1'b1, 1'b0, 1'b0, DST_NONE, 1'b0);
         5'd9:  u = mk(OPND_V3, OPND_OMS, 1'b0, 1'b1, 1'b0, DST_NONE, 1'b0);
         5'd10: u = mk(OPND_V5, OPND_S, 1'b0, 1'b0, 1'b0, DST_NONE, 1'b0);
         5'd11: u = mk(OPND_V7, OPND_S, 1'b0, 1'b1, 1'b0, DST_J2, 1'b0);
         5'd12: u = mk(OPND_V1, OPND_OMR, 1'b1, 1'b0, 1'b0, DST_NONE, 1'b0);
         5'd13: u = mk(OPND_V3, OPND_R, 1'b0, 1'b0, 1'b0, DST_NONE, 1'b0);
         5'd14: u = mk(OPND_V5, OPND_OMR, 1'b0, 1'b1, 1'b0, DST_NONE, 1'b0);
         5'd15: u = mk(OPND_V7, OPND_R, 1'b0, 1'b1, 1'b0, DST_J3, 1'b0);
         5'd16: u = mk(OPND_J1, OPND_J2, 1'b1, 1'b1, 1'b1, DST_NONE, 1'b0);
         5'd17: u = mk(OPND_J0, OPND_J3, 1'b0, 1'b0, 1'b1, DST_DET, 1'b0);
         5'd18: u = mk(OPND_J3, OPND_RES0, 1'b1, 1'b0, 1'b1, DST_NONE, 1'b0);
         5'd19: u = mk(OPND_J1, OPND_RES1, 1'b0, 1'b1, 1'b1, DST_NR, 1'b0);
         5'd20: u = mk(OPND_J0, OPND_RES1, 1'b1, 1'b0, 1'b1, DST_NONE, 1'b0);
         5'd21: u = mk(OPND_J2, OPND_RES0, 1'b0, 1'b1, 1'b1, DST_NS, 1'b1);
         default: ;
      endcase
      return u;
   endfunction

endpackage

FILE: src/einm_div.sv
module einm_div import einm_pkg::*; (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    start,
   input  logic signed [ACC_W-1:0] numer,
   input  logic signed [ACC_W-1:0] denom,
   output logic                    done,
   output logic signed [31:0]      quot
);

   // restoring division of |numer| * 2^16 by |denom|, one quotient bit a cycle
   localparam int QBITS = 33;

   logic [ACC_W-1:0] un_abs;
   logic [ACC_W-1:0] ud_abs;
   logic [63:0]      un;
   logic [63:0]      ud;
   logic [64:0]      shifted;
   logic             fits;
   logic             big;

   logic             busy_ff;
   logic             done_ff;
   logic signed [31:0] quot_ff;
   logic [5:0]       cnt_ff;
   logic [64:0]      rem_ff;
   logic [63:0]      ud_ff;
   logic [QBITS-1:0] nb_ff;
   logic [QBITS-1:0] q_ff;
   logic             neg_ff;
   logic             ovf_ff;

   assign un_abs = numer[ACC_W-1] ? (ACC_W'(0) - numer) : numer;
   assign ud_abs = denom[ACC_W-1] ? (ACC_W'(0) - denom) : denom;
   assign un = un_abs[63:0];
   assign ud = ud_abs[63:0];
   assign shifted = {rem_ff[63:0], nb_ff[QBITS-1]};
   assign fits = shifted >= {1'b0, ud_ff};
   assign big = ovf_ff | q_ff[32] | q_ff[31];

   always_ff @(posedge clock) begin
      done_ff <= 1'b0;
      if (reset) begin
         busy_ff <= 1'b0;
      end else if (start) begin
         busy_ff <= 1'b1;
         ud_ff <= ud;
         rem_ff <= {18'd0, un[63:17]};
         nb_ff <= {un[16:0], 16'd0};
         q_ff <= '0;
         neg_ff <= numer[ACC_W-1] ^ denom[ACC_W-1];
         ovf_ff <= {17'd0, un[63:17]} >= ud;
         cnt_ff <= 6'(QBITS);
      end else if (busy_ff) begin
         if (ovf_ff || cnt_ff == 6'd0) begin
            busy_ff <= 1'b0;
            done_ff <= 1'b1;
            if (big) begin
               quot_ff <= neg_ff ? 32'sh80000000 : 32'sh7fffffff;
            end else begin
               quot_ff <= neg_ff ? (32'sd0 - q_ff[31:0]) : q_ff[31:0];
            end
         end else begin
            rem_ff <= fits ? (shifted - {1'b0, ud_ff}) : shifted;
            q_ff <= {q_ff[QBITS-2:0], fits};
            nb_ff <= {nb_ff[QBITS-2:0], 1'b0};
            cnt_ff <= cnt_ff - 6'd1;
         end
      end
   end

   assign done = done_ff;
   assign quot = quot_ff;

endmodule

FILE: src/element_inverse_map_newton_unit.sv
// channel   ports                              handshake
// request   start, busy, req_data              taken when start and not busy
// result    rsp_valid, rsp_data                one-cycle strobe, cannot be held off
// csr       csr_valid, csr_ready, csr_index,   taken when csr_valid and csr_ready
//           csr_wdata
//
// one request at a time; busy stays high until its result is strobed
// a newton step runs on one shared 32x32 multiplier and one serial divider;
// a step's length is set by the mac program and by the divider, which stops
// early when its quotient overflows; an unused element kind returns zeros
// in the cycle after the request
// synchronous active-high reset clears the vertices and the control state
module element_inverse_map_newton_unit import einm_pkg::*; #(
   parameter int MAX_STEPS = 10,
   parameter int RESIDUAL_TOLERANCE = 4
) (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 start,
   output logic                 busy,
   input  req_type              req_data,
   output logic                 rsp_valid,
   output rsp_type              rsp_data,
   input  logic                 csr_valid,
   output logic                 csr_ready,
   input  logic [CSR_IDX_W-1:0] csr_index,
   input  logic [31:0]          csr_wdata
);

   localparam int STEP_W = $clog2(MAX_STEPS + 1);

   typedef enum logic [3:0] {
      S_IDLE, S_PREP, S_RES, S_RES_DRAIN, S_CHECK, S_JAC, S_JAC_DRAIN,
      S_SOLVE, S_DIV_R, S_DIV_S
   } state_type;

   state_type state_ff;

   // vertex registers, x at even index and y at odd index
   logic signed [31:0] vtx_ff [VERTEX_COUNT];

   logic [1:0]         mode_ff;
   logic signed [31:0] px_ff, py_ff;
   logic signed [31:0] r_ff, s_ff, omr_ff, oms_ff, otri_ff;
   logic signed [31:0] w_ff [4];
   logic signed [31:0] j_ff [4];
   logic signed [31:0] res0_ff, res1_ff;
   logic signed [ACC_W-1:0] det_ff, nr_ff, ns_ff, acc_ff;
   logic [STEP_W-1:0]  steps_ff;
   logic [PC_W-1:0]    pc_ff;

   // mac pipeline: multiply, then accumulate and write back
   logic signed [63:0] prod_ff;
   uop_type            ctl_ff;
   logic               ctl_vld_ff;

   logic               rsp_valid_ff;
   rsp_type            rsp_data_ff;

   uop_type                 cur_uop;
   logic                    issue;
   logic signed [31:0]      opa, opb;
   logic signed [ACC_W-1:0] term, acc_base, acc_new;
   logic signed [31:0]      acc_sat;
   logic [32:0]             mag0, mag1;
   logic                    small_res;
   logic                    is_line;
   logic                    zero_den;
   logic                    div_start, div_done;
   logic signed [ACC_W-1:0] div_num, div_den;
   logic signed [31:0]      div_quot;

   function automatic logic signed [31:0] pick(input opnd_type sel);
      case (sel)
         OPND_V0:   return vtx_ff[0];
         OPND_V1:   return vtx_ff[1];
         OPND_V2:   return vtx_ff[2];
         OPND_V3:   return vtx_ff[3];
         OPND_V4:   return vtx_ff[4];
         OPND_V5:   return vtx_ff[5];
         OPND_V6:   return vtx_ff[6];
         OPND_V7:   return vtx_ff[7];
         OPND_R:    return r_ff;
         OPND_S:    return s_ff;
         OPND_OMR:  return omr_ff;
         OPND_OMS:  return oms_ff;
         OPND_OTRI: return otri_ff;
         OPND_W0:   return w_ff[0];
         OPND_W1:   return w_ff[1];
         OPND_W2:   return w_ff[2];
         OPND_W3:   return w_ff[3];
         OPND_J0:   return j_ff[0];
         OPND_J1:   return j_ff[1];
         OPND_J2:   return j_ff[2];
         OPND_J3:   return j_ff[3];
         OPND_RES0: return res0_ff;
         OPND_RES1: return res1_ff;
         default:   return 32'sd0;
      endcase
   endfunction

   function automatic logic [32:0] abs33(input logic signed [31:0] x);
      return x[31] ? (33'd0 - {1'b1, x}) : {1'b0, x};
   endfunction

   assign is_line = (mode_ff == MODE_LINE);
   assign cur_uop = (state_ff == S_RES) ? uop_res(mode_ff, pc_ff) : uop_jac(pc_ff);
   assign issue = (state_ff == S_RES) || (state_ff == S_JAC);
   assign opa = pick(cur_uop.a);
   assign opb = pick(cur_uop.b);

   // q16.16 products are floored before summing, exact ones are not
   assign term = ctl_ff.full ? {{(ACC_W-64){prod_ff[63]}}, prod_ff}
                             : {{(ACC_W-48){prod_ff[63]}}, prod_ff[63:16]};
   assign acc_base = ctl_ff.clr ? ACC_W'(0) : acc_ff;
   assign acc_new = ctl_ff.neg ? (acc_base - term) : (acc_base + term);
   assign acc_sat = sat32(acc_new);

   assign mag0 = abs33(res0_ff);
   assign mag1 = abs33(res1_ff);
   assign small_res = (mag0 < 33'(RESIDUAL_TOLERANCE)) && (mag1 < 33'(RESIDUAL_TOLERANCE));

   assign zero_den = is_line ? (j_ff[0] == 32'sd0) : (det_ff == ACC_W'(0));
   assign div_start = ((state_ff == S_SOLVE) && !zero_den) ||
                      ((state_ff == S_DIV_R) && div_done && !is_line);
   assign div_num = (state_ff == S_SOLVE) ? (is_line ? sext32(res0_ff) : nr_ff) : ns_ff;
   assign div_den = is_line ? sext32(j_ff[0]) : det_ff;

   einm_div u_div (
      .clock (clock),
      .reset (reset),
      .start (div_start),
      .numer (div_num),
      .denom (div_den),
      .done  (div_done),
      .quot  (div_quot)
   );

   always_ff @(posedge clock) begin
      rsp_valid_ff <= 1'b0;
      ctl_vld_ff <= 1'b0;
      if (reset) begin
         state_ff <= S_IDLE;
         for (int i = 0; i < VERTEX_COUNT; i++) begin
            vtx_ff[i] <= 32'sd0;
         end
      end else begin
         // csr writes land at once, so the sender keeps them to idle; out-of-range indexes drop
         if (csr_valid && csr_index < CSR_IDX_W'(VERTEX_COUNT)) begin
            vtx_ff[csr_index[2:0]] <= csr_wdata;
         end

         // accumulate stage
         if (ctl_vld_ff) begin
            acc_ff <= acc_new;
            case (ctl_ff.dst)
               DST_W0:   w_ff[0] <= acc_sat;
               DST_W1:   w_ff[1] <= acc_sat;
               DST_W2:   w_ff[2] <= acc_sat;
               DST_W3:   w_ff[3] <= acc_sat;
               DST_RES0: res0_ff <= sat32(sext32(px_ff) - sext32(acc_sat));
               DST_RES1: res1_ff <= sat32(sext32(py_ff) - sext32(acc_sat));
               DST_J0:   j_ff[0] <= acc_sat;
               DST_J1:   j_ff[1] <= acc_sat;
               DST_J2:   j_ff[2] <= acc_sat;
               DST_J3:   j_ff[3] <= acc_sat;
               DST_DET:  det_ff <= acc_new;
               DST_NR:   nr_ff <= acc_new;
               DST_NS:   ns_ff <= acc_new;
               default: ;
            endcase
         end

         // multiply stage
         if (issue) begin
            prod_ff <= opa * opb;
            ctl_ff <= cur_uop;
            ctl_vld_ff <= 1'b1;
            pc_ff <= pc_ff + PC_W'(1);
         end

         case (state_ff)
            S_IDLE: begin
               if (start) begin
                  mode_ff <= req_data.mode;
                  px_ff <= req_data.point_x;
                  py_ff <= req_data.point_y;
                  steps_ff <= '0;
                  if (req_data.mode == MODE_LINE) begin
                     r_ff <= Q_HALF;
                     s_ff <= 32'sd0;
                     state_ff <= S_PREP;
                  end else if (req_data.mode == MODE_TRI) begin
                     r_ff <= Q_THIRD;
                     s_ff <= Q_THIRD;
                     state_ff <= S_PREP;
                  end else if (req_data.mode == MODE_QUAD) begin
                     r_ff <= Q_HALF;
                     s_ff <= Q_HALF;
                     state_ff <= S_PREP;
                  end else begin
                     // unused element kind: answer zeros at once
                     rsp_valid_ff <= 1'b1;
                     rsp_data_ff <= '0;
                  end
               end
            end
            S_PREP: begin
               omr_ff <= sat32(sext32(Q_ONE) - sext32(r_ff));
               oms_ff <= sat32(sext32(Q_ONE) - sext32(s_ff));
               otri_ff <= sat32(sext32(Q_ONE) - sext32(r_ff) - sext32(s_ff));
               // constant jacobian of the linear elements
               j_ff[0] <= sat32(sext32(vtx_ff[0]) - sext32(vtx_ff[2]));
               j_ff[1] <= sat32(sext32(vtx_ff[0]) - sext32(vtx_ff[4]));
               j_ff[2] <= sat32(sext32(vtx_ff[1]) - sext32(vtx_ff[3]));
               j_ff[3] <= sat32(sext32(vtx_ff[1]) - sext32(vtx_ff[5]));
               if (is_line) begin
                  res1_ff <= 32'sd0;
               end
               pc_ff <= '0;
               state_ff <= S_RES;
            end
            S_RES: begin
               if (cur_uop.last) begin
                  state_ff <= S_RES_DRAIN;
               end
            end
            S_RES_DRAIN: begin
               state_ff <= S_CHECK;
            end
            S_CHECK: begin
               if (small_res || steps_ff >= STEP_W'(MAX_STEPS)) begin
                  rsp_valid_ff <= 1'b1;
                  rsp_data_ff.coord_r <= r_ff;
                  rsp_data_ff.coord_s <= s_ff;
                  rsp_data_ff.steps_taken <= 4'(steps_ff);
                  rsp_data_ff.converged <= small_res;
                  rsp_data_ff.singular <= 1'b0;
                  state_ff <= S_IDLE;
               end else if (is_line) begin
                  state_ff <= S_SOLVE;
               end else begin
                  pc_ff <= (mode_ff == MODE_TRI) ? JAC_COMMON_PC : '0;
                  state_ff <= S_JAC;
               end
            end
            S_JAC: begin
               if (cur_uop.last) begin
                  state_ff <= S_JAC_DRAIN;
               end
            end
            S_JAC_DRAIN: begin
               state_ff <= S_SOLVE;
            end
            S_SOLVE: begin
               if (zero_den) begin
                  rsp_valid_ff <= 1'b1;
                  rsp_data_ff.coord_r <= r_ff;
                  rsp_data_ff.coord_s <= s_ff;
                  rsp_data_ff.steps_taken <= 4'(steps_ff);
                  rsp_data_ff.converged <= 1'b0;
                  rsp_data_ff.singular <= 1'b1;
                  state_ff <= S_IDLE;
               end else begin
                  state_ff <= S_DIV_R;
               end
            end
            S_DIV_R: begin
               if (div_done) begin
                  r_ff <= sat32(sext32(r_ff) - sext32(div_quot));
                  if (is_line) begin
                     steps_ff <= steps_ff + STEP_W'(1);
                     state_ff <= S_PREP;
                  end else begin
                     state_ff <= S_DIV_S;
                  end
               end
            end
            S_DIV_S: begin
               if (div_done) begin
                  s_ff <= sat32(sext32(s_ff) - sext32(div_quot));
                  steps_ff <= steps_ff + STEP_W'(1);
                  state_ff <= S_PREP;
               end
            end
            default: begin
               state_ff <= S_IDLE;
            end
         endcase
      end
   end

   assign busy = (state_ff != S_IDLE);
   assign csr_ready = 1'b1;
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data = rsp_data_ff;

   // a result is only strobed while the sequencer is idle
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff |-> state_ff == S_IDLE)
      else $error("result strobed while busy");

   // a request never ends both converged and singular
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff |-> !(rsp_data_ff.converged && rsp_data_ff.singular))
      else $error("converged and singular together");

   // the divider only answers while an update is waiting for it
   assert property (@(posedge clock) disable iff (reset)
      div_done |-> (state_ff == S_DIV_R || state_ff == S_DIV_S))
      else $error("divider result outside update");

   // step count never passes the limit
   assert property (@(posedge clock) disable iff (reset)
      busy |-> steps_ff <= STEP_W'(MAX_STEPS))
      else $error("step count beyond limit");

endmodule
